### src/srgbw_pkg.sv
// package: constants, register map and color helper functions for the pixel writer
package srgbw_pkg;

   localparam int DEST_WIDTH_DEFAULT  = 320;
   localparam int DEST_HEIGHT_DEFAULT = 240;

   localparam logic [15:0] SOURCE_WIDTH_RESET  = 16'd320;
   localparam logic [15:0] SOURCE_HEIGHT_RESET = 16'd240;

   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;

   localparam logic REG_SOURCE_WIDTH  = 1'b0;
   localparam logic REG_SOURCE_HEIGHT = 1'b1;

   localparam int COEF_Y_R  = 66;
   localparam int COEF_Y_G  = 129;
   localparam int COEF_Y_B  = 25;
   localparam int COEF_CB_R = -38;
   localparam int COEF_CB_G = -74;
   localparam int COEF_CB_B = 112;
   localparam int COEF_CR_R = 112;
   localparam int COEF_CR_G = -94;
   localparam int COEF_CR_B = -18;
   localparam int ROUND_BIAS = 128;
   localparam int LUMA_OFFSET = 16;
   localparam int CHROMA_OFFSET = 128;
   localparam int COLOR_MAX = 255;

   localparam int SUM_WIDTH = 18;

   typedef logic signed [SUM_WIDTH-1:0] color_sum_type;

   function automatic color_sum_type color_sum(input logic [7:0] r, input logic [7:0] g,
                                               input logic [7:0] b, input int cr,
                                               input int cg, input int cb);
      color_sum_type rs;
      color_sum_type gs;
      color_sum_type bs;
      rs = $signed({10'b0, r});
      gs = $signed({10'b0, g});
      bs = $signed({10'b0, b});
      return rs * SUM_WIDTH'(cr) + gs * SUM_WIDTH'(cg) + bs * SUM_WIDTH'(cb)
             + SUM_WIDTH'(ROUND_BIAS);
   endfunction

   function automatic logic [7:0] shift_clamp(input color_sum_type sum, input int offset);
      logic signed [10:0] v;
      v = 11'(sum >>> 8) + 11'(offset);
      if (v < 11'sd0) begin
         return 8'd0;
      end else if (v > 11'(COLOR_MAX)) begin
         return 8'(COLOR_MAX);
      end else begin
         return v[7:0];
      end
   endfunction

endpackage

### src/srgbw_if.sv
// interfaces: pixel request channel and frame-store write channel
interface srgbw_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] src_x;
   logic [15:0] src_y;
   logic [7:0]  red;
   logic [7:0]  green;
   logic [7:0]  blue;

   modport source(output valid, src_x, src_y, red, green, blue, input ready);
   modport sink(input valid, src_x, src_y, red, green, blue, output ready);
endinterface

interface srgbw_rsp_if;
   logic       valid;
   logic       ready;
   logic [8:0] dest_x;
   logic [7:0] dest_y;
   logic [7:0] luma;
   logic [7:0] blue_diff;
   logic [7:0] red_diff;

   modport source(output valid, dest_x, dest_y, luma, blue_diff, red_diff, input ready);
   modport sink(input valid, dest_x, dest_y, luma, blue_diff, red_diff, output ready);
endinterface

### src/scaled_rgb_to_ycbcr_pixel_writer_top.sv
// top level: pipelined nearest-neighbor scaler and rgb to ycbcr converter
//
// Accepts one pixel request per clock while the write is not stalled and emits at most
// one frame-store write per request, in order. One entry stage forms src*DEST and the
// color sums, then a restoring divider resolves one quotient bit per stage for both axes
// at once, and its last stage drives the write. Pixels at or beyond the configured
// source size, or any pixel while a source size is zero, produce no write. A stalled
// write holds the whole pipeline. Source size registers are written over the APB port
// at 0x0 (width) and 0x4 (height) and should only change while no pixels are in flight.
module scaled_rgb_to_ycbcr_pixel_writer_top #(
   parameter int DEST_WIDTH  = srgbw_pkg::DEST_WIDTH_DEFAULT,
   parameter int DEST_HEIGHT = srgbw_pkg::DEST_HEIGHT_DEFAULT
) (
   input  logic                                     clock,
   input  logic                                     reset,
   srgbw_req_if.sink                                req_chan,
   srgbw_rsp_if.source                              rsp_chan,
   input  logic                                     psel,
   input  logic                                     penable,
   input  logic                                     pwrite,
   input  logic [srgbw_pkg::CSR_ADDR_WIDTH-1:0]     paddr,
   input  logic [srgbw_pkg::CSR_DATA_WIDTH-1:0]     pwdata,
   output logic [srgbw_pkg::CSR_DATA_WIDTH-1:0]     prdata,
   output logic                                     pready
);

   localparam int QX = (DEST_WIDTH > 1) ? $clog2(DEST_WIDTH) : 1;
   localparam int QY = (DEST_HEIGHT > 1) ? $clog2(DEST_HEIGHT) : 1;
   localparam int QN = (QX > QY) ? QX : QY;
   localparam int DW = 16 + QN;

   typedef struct packed {
      logic                     valid;
      logic [DW-1:0]            num_x;
      logic [DW-1:0]            num_y;
      srgbw_pkg::color_sum_type y_sum;
      srgbw_pkg::color_sum_type cb_sum;
      srgbw_pkg::color_sum_type cr_sum;
   } entry_stage_type;

   typedef struct packed {
      logic          valid;
      logic [DW-1:0] rem_x;
      logic [DW-1:0] rem_y;
      logic [QN-1:0] quo_x;
      logic [QN-1:0] quo_y;
      logic [7:0]    luma;
      logic [7:0]    blue_diff;
      logic [7:0]    red_diff;
   } div_stage_type;

   logic [15:0]     source_width_ff;
   logic [15:0]     source_height_ff;
   logic            csr_write;
   logic            advance;
   logic            keep;
   entry_stage_type ent_ff;
   entry_stage_type ent_in;
   div_stage_type   head;
   div_stage_type   stg_ff [1:QN];
   div_stage_type   stg_in [1:QN];

   // configuration registers
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         source_width_ff  <= srgbw_pkg::SOURCE_WIDTH_RESET;
         source_height_ff <= srgbw_pkg::SOURCE_HEIGHT_RESET;
      end else if (csr_write) begin
         if (paddr[2] == srgbw_pkg::REG_SOURCE_WIDTH) begin
            source_width_ff <= pwdata[15:0];
         end else begin
            source_height_ff <= pwdata[15:0];
         end
      end
   end

   always_comb begin
      if (paddr[2] == srgbw_pkg::REG_SOURCE_WIDTH) begin
         prdata = {16'b0, source_width_ff};
      end else begin
         prdata = {16'b0, source_height_ff};
      end
   end

   // pipeline control
   assign advance        = !rsp_chan.valid || rsp_chan.ready;
   assign req_chan.ready = advance;

   // entry stage
   assign keep = (source_width_ff != 16'd0) && (source_height_ff != 16'd0)
                 && (req_chan.src_x < source_width_ff) && (req_chan.src_y < source_height_ff);

   always_comb begin
      ent_in.valid  = req_chan.valid && keep;
      ent_in.num_x  = DW'(req_chan.src_x) * DW'(DEST_WIDTH);
      ent_in.num_y  = DW'(req_chan.src_y) * DW'(DEST_HEIGHT);
      ent_in.y_sum  = srgbw_pkg::color_sum(req_chan.red, req_chan.green, req_chan.blue,
                                           srgbw_pkg::COEF_Y_R, srgbw_pkg::COEF_Y_G,
                                           srgbw_pkg::COEF_Y_B);
      ent_in.cb_sum = srgbw_pkg::color_sum(req_chan.red, req_chan.green, req_chan.blue,
                                           srgbw_pkg::COEF_CB_R, srgbw_pkg::COEF_CB_G,
                                           srgbw_pkg::COEF_CB_B);
      ent_in.cr_sum = srgbw_pkg::color_sum(req_chan.red, req_chan.green, req_chan.blue,
                                           srgbw_pkg::COEF_CR_R, srgbw_pkg::COEF_CR_G,
                                           srgbw_pkg::COEF_CR_B);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_ff.valid <= 1'b0;
      end else if (advance) begin
         ent_ff <= ent_in;
      end
   end

   always_comb begin
      head.valid     = ent_ff.valid;
      head.rem_x     = ent_ff.num_x;
      head.rem_y     = ent_ff.num_y;
      head.quo_x     = '0;
      head.quo_y     = '0;
      head.luma      = srgbw_pkg::shift_clamp(ent_ff.y_sum, srgbw_pkg::LUMA_OFFSET);
      head.blue_diff = srgbw_pkg::shift_clamp(ent_ff.cb_sum, srgbw_pkg::CHROMA_OFFSET);
      head.red_diff  = srgbw_pkg::shift_clamp(ent_ff.cr_sum, srgbw_pkg::CHROMA_OFFSET);
   end

   // restoring divider, one quotient bit per stage, msb first
   for (genvar k = 1; k <= QN; k++) begin : g_div
      div_stage_type src;
      logic [DW-1:0] div_x;
      logic [DW-1:0] div_y;
      logic          bit_x;
      logic          bit_y;

      if (k == 1) begin : g_first
         assign src = head;
      end else begin : g_next
         assign src = stg_ff[k-1];
      end

      assign div_x = DW'(source_width_ff) << (QN - k);
      assign div_y = DW'(source_height_ff) << (QN - k);
      assign bit_x = src.rem_x >= div_x;
      assign bit_y = src.rem_y >= div_y;

      always_comb begin
         stg_in[k]       = src;
         stg_in[k].rem_x = bit_x ? src.rem_x - div_x : src.rem_x;
         stg_in[k].rem_y = bit_y ? src.rem_y - div_y : src.rem_y;
         stg_in[k].quo_x = (src.quo_x << 1) | QN'(bit_x);
         stg_in[k].quo_y = (src.quo_y << 1) | QN'(bit_y);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            stg_ff[k].valid <= 1'b0;
         end else if (advance) begin
            stg_ff[k] <= stg_in[k];
         end
      end
   end

   // frame-store write
   assign rsp_chan.valid     = stg_ff[QN].valid;
   assign rsp_chan.dest_x    = 9'(stg_ff[QN].quo_x);
   assign rsp_chan.dest_y    = 8'(stg_ff[QN].quo_y);
   assign rsp_chan.luma      = stg_ff[QN].luma;
   assign rsp_chan.blue_diff = stg_ff[QN].blue_diff;
   assign rsp_chan.red_diff  = stg_ff[QN].red_diff;

endmodule
